// File: hw/rtl/cfas_pkg.sv
// ----------------------------------------------------------------------------
// cfas_pkg
// Shared types, character codes and helpers for the CAN frame text serializer.
// ----------------------------------------------------------------------------
package cfas_pkg;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChRemote = 8'h52;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChAlpha  = 8'h41;
  localparam logic [7:0] MaxBytes = 8'd8;

  // Classified frame, as handed from front to back.
  typedef struct packed {
    logic [29:0] id_val;   // masked identifier
    logic        long_id;  // 1: eight digits, 0: three digits
    logic        remote;
    logic        rlen_ok;  // remote length digit printed
    logic [3:0]  rlen;
    logic [3:0]  nbytes;   // clamped byte count, 0..8
    logic        sep;      // dot between data bytes
    logic [63:0] data;
  } cfas_desc_t;

  typedef enum logic [2:0] {
    StId,
    StSpace,
    StRemote,
    StRlen,
    StHi,
    StLo,
    StDot
  } cfas_state_e;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = ChZero + {4'b0, nib};
    end else begin
      c = ChAlpha + {4'b0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/cfas_front.sv
// ----------------------------------------------------------------------------
// cfas_front
// Holds the separator register and classifies each accepted frame.
// ----------------------------------------------------------------------------
module cfas_front
  import cfas_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] frame_id_i,
  input  logic [7:0]  frame_len_i,
  input  logic [63:0] frame_data_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output cfas_desc_t  q_desc_o
);

  logic sep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= 1'b0;
    end else if (cfg_we_i) begin
      sep_q <= cfg_wdata_i;
    end
  end

  logic id_err, id_eff;

  assign id_err = frame_id_i[29];
  assign id_eff = frame_id_i[31];

  always_comb begin
    if (id_err) begin
      q_desc_o.id_val = frame_id_i[29:0];
    end else if (id_eff) begin
      q_desc_o.id_val = {1'b0, frame_id_i[28:0]};
    end else begin
      q_desc_o.id_val = {19'b0, frame_id_i[10:0]};
    end
    q_desc_o.long_id = id_err | id_eff;
    q_desc_o.remote  = frame_id_i[30];
    q_desc_o.rlen_ok = (frame_len_i != 8'd0) && (frame_len_i <= MaxBytes);
    q_desc_o.rlen    = frame_len_i[3:0];
    q_desc_o.nbytes  = (frame_len_i > MaxBytes) ? MaxBytes[3:0] : frame_len_i[3:0];
    q_desc_o.sep     = sep_q;
    q_desc_o.data    = frame_data_i;
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

// File: hw/rtl/cfas_queue.sv
// ----------------------------------------------------------------------------
// cfas_queue
// Small register FIFO of classified frames between front and back.
// ----------------------------------------------------------------------------
module cfas_queue
  import cfas_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cfas_desc_t desc_i,
  output logic       full_o,
  input  logic       pop_i,
  output cfas_desc_t desc_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  cfas_desc_t            mem_q [DEPTH];
  logic [PtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign desc_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= desc_i;
    end
  end

  // count never exceeds the depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= FullCnt))
    else $error("queue count above depth");

endmodule

// File: hw/rtl/cfas_back.sv
// ----------------------------------------------------------------------------
// cfas_back
// Character sequencer: turns one classified frame into its text, one
// character per cycle while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module cfas_back
  import cfas_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfas_desc_t desc_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o
);

  cfas_state_e state_q, state_d;
  logic        busy_q, busy_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [3:0]  left_q, left_d;
  logic [63:0] data_q, data_d;
  logic [31:0] id_q, id_d;
  logic        remote_q, remote_d;
  logic        rlen_ok_q, rlen_ok_d;
  logic [3:0]  rlen_q, rlen_d;
  logic        sep_q, sep_d;

  logic        ovalid_q, ovalid_d;
  logic [7:0]  char_q, char_d;
  logic        last_q, last_d;

  logic        adv;
  logic        emit_last;
  logic [7:0]  ch;

  assign adv = !ovalid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    left_d    = left_q;
    data_d    = data_q;
    id_d      = id_q;
    remote_d  = remote_q;
    rlen_ok_d = rlen_ok_q;
    rlen_d    = rlen_q;
    sep_d     = sep_q;
    ch        = ChSpace;
    emit_last = 1'b0;

    unique case (state_q)
      StId: begin
        ch = hex_char(id_q[{cnt_q, 2'b00} +: 4]);
        if (cnt_q == 3'd0) begin
          state_d = StSpace;
        end else begin
          cnt_d = cnt_q - 3'd1;
        end
      end
      StSpace: begin
        ch = ChSpace;
        if (remote_q) begin
          state_d = StRemote;
        end else if (left_q == 4'd0) begin
          emit_last = 1'b1;
        end else begin
          state_d = StHi;
        end
      end
      StRemote: begin
        ch        = ChRemote;
        emit_last = !rlen_ok_q;
        state_d   = StRlen;
      end
      StRlen: begin
        ch        = hex_char(rlen_q);
        emit_last = 1'b1;
      end
      StHi: begin
        ch      = hex_char(data_q[63:60]);
        state_d = StLo;
      end
      StLo: begin
        ch     = hex_char(data_q[59:56]);
        left_d = left_q - 4'd1;
        data_d = {data_q[55:0], 8'h00};
        if (left_q == 4'd1) begin
          emit_last = 1'b1;
        end else if (sep_q) begin
          state_d = StDot;
        end else begin
          state_d = StHi;
        end
      end
      StDot: begin
        ch      = ChDot;
        state_d = StHi;
      end
      default: begin
        ch = ChSpace;
      end
    endcase

    if (!adv) begin
      state_d = state_q;
      cnt_d   = cnt_q;
      left_d  = left_q;
      data_d  = data_q;
    end

    // next frame loads as the current one finishes, no gap between them when one is queued
    pop_o = adv && (!busy_q || emit_last) && !empty_i;
    if (adv && busy_q && emit_last) begin
      busy_d = 1'b0;
    end
    if (pop_o) begin
      busy_d    = 1'b1;
      state_d   = StId;
      cnt_d     = desc_i.long_id ? 3'd7 : 3'd2;
      left_d    = desc_i.nbytes;
      data_d    = desc_i.data;
      id_d      = {2'b00, desc_i.id_val};
      remote_d  = desc_i.remote;
      rlen_ok_d = desc_i.rlen_ok;
      rlen_d    = desc_i.rlen;
      sep_d     = desc_i.sep;
    end

    ovalid_d = ovalid_q;
    char_d   = char_q;
    last_d   = last_q;
    if (adv) begin
      ovalid_d = busy_q;
      char_d   = ch;
      last_d   = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StId;
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    left_q    <= left_d;
    data_q    <= data_d;
    id_q      <= id_d;
    remote_q  <= remote_d;
    rlen_ok_q <= rlen_ok_d;
    rlen_q    <= rlen_d;
    sep_q     <= sep_d;
    char_q    <= char_d;
    last_q    <= last_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_char_o  = char_q;
  assign last_char_o = last_q;

  a_dot_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && char_q == ChDot) |-> !last_q)
    else $error("dot marked as last character");

  a_rlen_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && state_q == StRlen) |-> rlen_ok_q)
    else $error("length digit on remote frame without valid length");

  a_bytes_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (state_q == StHi || state_q == StLo || state_q == StDot))
      |-> (left_q != 4'd0))
    else $error("data state with no bytes left");

endmodule

// File: hw/rtl/can_frame_to_ascii_serializer.sv
// ----------------------------------------------------------------------------
// can_frame_to_ascii_serializer
// Classic CAN frame to compact ASCII text, one character per output item.
// ----------------------------------------------------------------------------
// Each input item is one frame: identifier word with flags, length byte and
// eight data bytes. The block prints the identifier in uppercase hex (eight
// digits for error or extended frames, three for standard), a space, then
// either 'R' plus an optional length digit for remote frames, or up to eight
// data bytes as hex pairs, dot separated when use_separator is set. The final
// character carries last_char_o. A frame is 4 to 32 characters long: the back
// sequencer emits one character per cycle into its output register unless the
// output stalls, and consecutive frames follow with no gap in between. The front
// classifies and queues frames (QUEUE_DEPTH entries), so new frames are taken
// while earlier text still drains. The use_separator register is sampled into
// each frame as it is accepted, so write it only while no frame is in flight.
// ----------------------------------------------------------------------------
module can_frame_to_ascii_serializer
  import cfas_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: use_separator
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // frame input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] frame_id_i,
  input  logic [7:0]  frame_len_i,
  input  logic [63:0] frame_data_i,
  // character output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        last_char_o
);

  cfas_desc_t push_desc, pop_desc;
  logic       q_push, q_pop, q_full, q_empty;

  // front: separator register and frame classification
  cfas_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .frame_id_i   (frame_id_i),
    .frame_len_i  (frame_len_i),
    .frame_data_i (frame_data_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_desc_o     (push_desc)
  );

  // decoupling queue
  cfas_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (push_desc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .desc_o  (pop_desc),
    .empty_o (q_empty)
  );

  // back: character sequencer with registered output
  cfas_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_i      (pop_desc),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

// File: tb/can_frame_to_ascii_serializer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// can_frame_to_ascii_serializer_test
// Self-checking bench for the CAN frame to compact ASCII serializer.
// ----------------------------------------------------------------------------
// A short table of hand-picked frames (flag combinations, length and identifier
// extremes, separator on and off) is followed by about 330 random frames in
// three idle profiles. Every accepted frame is rendered to text by a local
// model, unless its table row gives the text, and each character leaving the
// block is compared with the oldest character still owed.
// ----------------------------------------------------------------------------
module can_frame_to_ascii_serializer_test;
  import cfas_pkg::*;

  typedef logic [7:0] char_q_t[$];

  // One character still owed by the block.
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } owed_char_t;

  // One row of the directed table. An empty text means the model renders it.
  typedef struct {
    logic        sep;
    logic [31:0] id;
    logic [7:0]  len;
    logic [63:0] data;
    string       text;
  } frame_row_t;

  localparam logic [127:0] HexDigits = "0123456789ABCDEF";

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] frame_id_i;
  logic [7:0]  frame_len_i;
  logic [63:0] frame_data_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_char_o;
  logic        last_char_o;

  owed_char_t  owed_chars[$];
  frame_row_t  directed_rows[$];
  logic        sep_setting;     // separator value the block holds right now
  int          send_idle_pct;   // chance per cycle of a gap before a frame
  int          stall_pct;       // chance per cycle of output stall
  int          mismatch_count = 0;

  can_frame_to_ascii_serializer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .frame_id_i   (frame_id_i),
    .frame_len_i  (frame_len_i),
    .frame_data_i (frame_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .last_char_o  (last_char_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Text model
  // --------------------------------------------------------------------------
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return HexDigits[127 - 8 * nib -: 8];
  endfunction

  // Compact text of one frame, identifier first, exactly as the block prints it.
  function automatic char_q_t render_frame(input logic [31:0] id, input logic [7:0] len,
                                           input logic [63:0] data, input logic sep);
    char_q_t     chars;
    logic [31:0] shown;
    logic [7:0]  cur;
    int          digits;
    int          nbytes;
    int          d;
    int          i;
    // Error flag wins over extended; error frames keep the flag in the digits.
    if (id[29]) begin
      shown  = id & 32'h3FFF_FFFF;
      digits = 8;
    end else if (id[31]) begin
      shown  = id & 32'h1FFF_FFFF;
      digits = 8;
    end else begin
      shown  = id & 32'h0000_07FF;
      digits = 3;
    end
    for (d = digits - 1; d >= 0; d--) begin
      chars.push_back(hex_digit(shown[4 * d +: 4]));
    end
    chars.push_back(ChSpace);
    if (id[30]) begin
      // Remote: length digit only for 1..8, no data ever.
      chars.push_back(ChRemote);
      if (len != 8'd0 && len <= MaxBytes) begin
        chars.push_back(hex_digit(len[3:0]));
      end
    end else begin
      nbytes = (len > MaxBytes) ? 8 : int'(len);
      for (i = 0; i < nbytes; i++) begin
        cur = data[63 - 8 * i -: 8];
        chars.push_back(hex_digit(cur[7:4]));
        chars.push_back(hex_digit(cur[3:0]));
        if (sep && i + 1 < nbytes) begin
          chars.push_back(ChDot);
        end
      end
    end
    return chars;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Frame side
  // --------------------------------------------------------------------------
  // Presents one frame, waits for it to be taken, then queues its text.
  // Valid is left high; the caller lowers it when no frame follows at once.
  task automatic send_frame(input logic [31:0] id, input logic [7:0] len,
                            input logic [63:0] data, input string text);
    char_q_t chars;
    int      i;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_id_i   <= id;
    frame_len_i  <= len;
    frame_data_i <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // Taken at this edge; separator value is the one held since the last write.
    if (text.len() != 0) begin
      for (i = 0; i < text.len(); i++) chars.push_back(text[i]);
    end else begin
      chars = render_frame(id, len, data, sep_setting);
    end
    for (i = 0; i < chars.size(); i++) begin
      owed_chars.push_back('{ch: chars[i], last: (i == chars.size() - 1)});
    end
  endtask

  // Register write only with the block drained; write data then stays put.
  task automatic set_separator(input logic value);
    in_valid_i <= 1'b0;
    while (owed_chars.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sep_setting = value;
  endtask

  // Random frame: mostly legal lengths, flags weighted so that every path shows.
  task automatic send_random_frame();
    logic [31:0] id;
    logic [7:0]  len;
    logic [63:0] data;
    id = $urandom();
    if ($urandom_range(0, 15) != 0) begin
      id[31] = $urandom_range(0, 1);
      id[30] = ($urandom_range(0, 4) == 0);
      id[29] = ($urandom_range(0, 5) == 0);
    end
    if ($urandom_range(0, 9) < 8) begin
      len = $urandom_range(0, 8);
    end else begin
      len = $urandom_range(9, 255);
    end
    data = {$urandom(), $urandom()};
    send_frame(id, len, data, "");
  endtask

  function automatic void add_row(input logic sep, input logic [31:0] id,
                                  input logic [7:0] len, input logic [63:0] data,
                                  input string text);
    directed_rows.push_back('{sep: sep, id: id, len: len, data: data, text: text});
  endfunction

  // --------------------------------------------------------------------------
  // Character side: check against the oldest owed character, then pick stall.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : char_check
    owed_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_chars.size() == 0) begin
        flag_mismatch($sformatf("char %h last %b with nothing owed", out_char_o,
                                last_char_o));
      end else begin
        want = owed_chars.pop_front();
        if (out_char_o !== want.ch) begin
          flag_mismatch($sformatf("char %h, want %h", out_char_o, want.ch));
        end
        if (last_char_o !== want.last) begin
          flag_mismatch($sformatf("last %b on char %h, want %b", last_char_o,
                                  out_char_o, want.last));
        end
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(0, 99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int r;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 1'b0;
    in_valid_i     = 1'b0;
    frame_id_i     = '0;
    frame_len_i    = '0;
    frame_data_i   = '0;
    sep_setting    = 1'b0;
    send_idle_pct  = 26;
    stall_pct      = 83;

    // Separator off (reset value) first, then on.
    add_row(1'b0, 32'h0000_0000, 8'd0,   64'h0,                   "000 ");
    add_row(1'b0, 32'h0000_07FF, 8'd8,   64'hFFFF_FFFF_FFFF_FFFF, "7FF FFFFFFFFFFFFFFFF");
    add_row(1'b0, 32'hFFFF_FFFF, 8'd255, 64'h1234_5678_9ABC_DEF0, "3FFFFFFF R");
    add_row(1'b0, 32'h8000_0000, 8'd0,   64'hFFFF_FFFF_FFFF_FFFF, "00000000 ");
    add_row(1'b0, 32'h9FFF_FFFF, 8'd8,   64'h0123_4567_89AB_CDEF, "");
    add_row(1'b0, 32'h2000_0000, 8'd1,   64'hAB00_0000_0000_0000, "");
    add_row(1'b0, 32'h4000_0123, 8'd8,   64'h0,                   "123 R8");
    add_row(1'b0, 32'h4000_0123, 8'd0,   64'h0,                   "123 R");
    add_row(1'b0, 32'h4000_0123, 8'd9,   64'h0,                   "123 R");
    add_row(1'b0, 32'h6000_0001, 8'd3,   64'h5555_5555_5555_5555, "");  // remote error
    add_row(1'b0, 32'hC000_0ABC, 8'd4,   64'hAAAA_AAAA_AAAA_AAAA, "");
    add_row(1'b0, 32'h0000_0456, 8'd9,   64'h1122_3344_5566_7788, "");  // clamped
    add_row(1'b0, 32'h0000_0100, 8'd255, 64'h8877_6655_4433_2211, "");
    add_row(1'b0, 32'h1FFF_F800, 8'd2,   64'hDEAD_BEEF_0000_0000, "");  // junk above ID
    add_row(1'b0, 32'h0000_0555, 8'd5,   64'hC3A5_5A3C_0F1E_2D4B, "");
    add_row(1'b0, 32'h0000_02AA, 8'd7,   64'h7E81_00FF_1001_9966, "");
    add_row(1'b0, 32'hA000_0000, 8'd0,   64'h0,                   "");  // error over ext
    add_row(1'b1, 32'h0000_0123, 8'd8,   64'h0011_2233_4455_6677,
            "123 00.11.22.33.44.55.66.77");
    add_row(1'b1, 32'h9FFF_FFFF, 8'd8,   64'hFFFF_FFFF_FFFF_FFFF,
            "1FFFFFFF FF.FF.FF.FF.FF.FF.FF.FF");                       // longest text
    add_row(1'b1, 32'h0000_0001, 8'd1,   64'h5A00_0000_0000_0000, "");  // one byte, no dot
    add_row(1'b1, 32'h0000_0002, 8'd2,   64'h0F10_0000_0000_0000, "");
    add_row(1'b1, 32'h0000_07FF, 8'd0,   64'hFFFF_FFFF_FFFF_FFFF, "7FF ");
    add_row(1'b1, 32'h4000_07FF, 8'd1,   64'h0,                   "7FF R1");
    add_row(1'b1, 32'h8765_4321, 8'd200, 64'h0102_0408_1020_4080, "");

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].sep !== sep_setting) set_separator(directed_rows[i].sep);
      send_frame(directed_rows[i].id, directed_rows[i].len, directed_rows[i].data,
                 directed_rows[i].text);
    end

    // Random: sender idles little, output stalls a lot; separator still on.
    for (r = 0; r < 110; r++) send_random_frame();

    // Sender idles a lot, output stalls little; separator off.
    set_separator(1'b0);
    send_idle_pct = 83;
    stall_pct     = 26;
    for (r = 0; r < 110; r++) send_random_frame();

    // Full rate both ways; separator on again.
    set_separator(1'b1);
    send_idle_pct = 0;
    stall_pct     = 0;
    for (r = 0; r < 110; r++) send_random_frame();

    in_valid_i <= 1'b0;
    while (owed_chars.size() != 0) @(posedge clk_i);
    // Catch stray characters after the last owed one.
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run.
  initial begin : watchdog
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
